// File: hdl/rgbled_pkg.sv
package rgbled_pkg;

   localparam int RAMP_POINTS = 8;
   localparam int MAX_RESULTS = 8;
   localparam int RAMP_COUNT  = (RAMP_POINTS < MAX_RESULTS) ? RAMP_POINTS : MAX_RESULTS;
   localparam int IDX_W       = $clog2(RAMP_COUNT);
   localparam int RAMP_SPAN   = 2 * RAMP_POINTS;
   localparam int NUM_SOURCES = 3;

   localparam logic [7:0] RAMP_STEP_RESET = 8'd50;
   localparam int         CSR_ADDR_W      = 3;
   localparam logic       CSR_RAMP_STEP   = 1'b0;

   localparam logic [6:0] RAMP_TABLE [8] = '{7'd0, 7'd12, 7'd25, 7'd37,
                                             7'd50, 7'd72, 7'd85, 7'd100};

   typedef struct packed {
      logic             load_req;
      logic             select;
      logic             scale;
      logic             load_out;
      logic [IDX_W-1:0] idx;
      logic             last;
   } cmd_type;

   typedef struct packed {
      logic blink;
   } status_type;

   // floor(x / 255), exact over the range used here
   function automatic logic [15:0] div255(input logic [15:0] x);
      logic [16:0] sum;
      sum = 17'(x) + 17'd1 + 17'(x[15:8]);
      return 16'(sum >> 8);
   endfunction

   // table entry for a ramp point, only ever called with a constant
   function automatic logic [2:0] ramp_entry(input int k);
      int t;
      t = (k * 7) / (RAMP_POINTS - 1);
      if (t > 7) begin
         t = 7;
      end
      return 3'(t);
   endfunction

   function automatic logic [6:0] ramp_pct(input logic [IDX_W-1:0] i);
      logic [6:0] pct;
      pct = '0;
      for (int k = 0; k < RAMP_COUNT; k++) begin
         if (i == IDX_W'(k)) begin
            pct = RAMP_TABLE[ramp_entry(k)];
         end
      end
      return pct;
   endfunction

endpackage

// File: hdl/rgbled_ctrl.sv
module rgbled_ctrl
   import rgbled_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SEL   = 4'b0010,
      ST_SCALE = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;
   logic             emit_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_last = !status.blink || (idx_ff == IDX_W'(RAMP_COUNT - 1));

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      cmd.idx      = idx_ff;
      cmd.last     = emit_last;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_SEL;
            end
         end
         ST_SEL: begin
            cmd.select = 1'b1;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            idx_in    = '0;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_to_sel: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_SEL)
      else $error("accepted transaction did not start selection");

   a_idx_advance: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && cmd.load_out && !emit_last |=> idx_ff == $past(idx_ff) + 1'b1)
      else $error("ramp index did not advance");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && cmd.load_out && emit_last |=> state_ff == ST_IDLE)
      else $error("controller did not return to idle after final result");
`endif

endmodule

// File: hdl/rgbled_datapath.sv
module rgbled_datapath
   import rgbled_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   input  logic [1:0]            req_cmd,
   input  logic [31:0]           req_color,
   input  logic                  req_timed,
   input  logic [15:0]           req_on_ms,
   input  logic [15:0]           req_off_ms,
   input  cmd_type               cmd,
   output status_type            status,
   output logic                  rsp_blink,
   output logic [7:0]            rsp_red_level,
   output logic [7:0]            rsp_green_level,
   output logic [7:0]            rsp_blue_level,
   output logic [2:0]            rsp_ramp_index,
   output logic [6:0]            rsp_red_duty,
   output logic [6:0]            rsp_green_duty,
   output logic [6:0]            rsp_blue_duty,
   output logic [7:0]            rsp_step_ms,
   output logic [15:0]           rsp_pause_hi_ms,
   output logic [15:0]           rsp_pause_lo_ms,
   output logic                  rsp_last
);

   logic [7:0]  step_cfg_ff;
   logic        csr_wr;

   logic [31:0] src_color_ff [NUM_SOURCES];
   logic        src_timed_ff [NUM_SOURCES];
   logic [15:0] src_on_ff    [NUM_SOURCES];
   logic [15:0] src_off_ff   [NUM_SOURCES];

   logic [31:0] sel_color;
   logic        sel_timed;
   logic [15:0] sel_on;
   logic [15:0] sel_off;
   logic        sel_lit;

   logic [7:0]  alpha_ff;
   logic [7:0]  raw_r_ff, raw_g_ff, raw_b_ff;
   logic [15:0] prod_r_ff, prod_g_ff, prod_b_ff;
   logic [15:0] on_ff, off_ff;
   logic        blink_ff, blink_in;

   logic [7:0]  lvl_r_ff, lvl_g_ff, lvl_b_ff;
   logic [7:0]  step_ff, step_in;
   logic [15:0] phi_ff, phi_in;
   logic [15:0] plo_ff;
   logic        scale_en;
   logic [15:0] span_ms;

   logic [6:0]  pct;
   logic [15:0] duty_r, duty_g, duty_b;

   logic        o_blink_ff, o_last_ff;
   logic [7:0]  o_r_ff, o_g_ff, o_b_ff, o_step_ff;
   logic [2:0]  o_idx_ff;
   logic [6:0]  o_rd_ff, o_gd_ff, o_bd_ff;
   logic [15:0] o_phi_ff, o_plo_ff;

   // configuration
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[CSR_ADDR_W-1] == CSR_RAMP_STEP);
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_RAMP_STEP) ?
                       {24'd0, step_cfg_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_cfg_ff <= RAMP_STEP_RESET;
      end else if (csr_wr) begin
         step_cfg_ff <= csr_pwdata[7:0];
      end
   end

   // source store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SOURCES; s++) begin
            src_color_ff[s] <= '0;
            src_timed_ff[s] <= 1'b0;
            src_on_ff[s]    <= '0;
            src_off_ff[s]   <= '0;
         end
      end else if (cmd.load_req && (int'(req_cmd) < NUM_SOURCES)) begin
         src_color_ff[req_cmd] <= req_color;
         src_timed_ff[req_cmd] <= req_timed;
         src_on_ff[req_cmd]    <= req_on_ms;
         src_off_ff[req_cmd]   <= req_off_ms;
      end
   end

   // priority pick of the first lit source
   always_comb begin
      sel_color = '0;
      sel_timed = 1'b0;
      sel_on    = '0;
      sel_off   = '0;
      sel_lit   = 1'b0;
      for (int s = NUM_SOURCES - 1; s >= 0; s--) begin
         if (src_color_ff[s][23:0] != 24'd0) begin
            sel_color = src_color_ff[s];
            sel_timed = src_timed_ff[s];
            sel_on    = src_on_ff[s];
            sel_off   = src_off_ff[s];
            sel_lit   = 1'b1;
         end
      end
   end

   assign blink_in = sel_lit && sel_timed && (sel_on != 16'd0) && (sel_off != 16'd0);

   always_ff @(posedge clock) begin
      if (cmd.select) begin
         alpha_ff  <= sel_color[31:24];
         raw_r_ff  <= sel_color[23:16];
         raw_g_ff  <= sel_color[15:8];
         raw_b_ff  <= sel_color[7:0];
         prod_r_ff <= 16'(sel_color[23:16]) * 16'(sel_color[31:24]);
         prod_g_ff <= 16'(sel_color[15:8]) * 16'(sel_color[31:24]);
         prod_b_ff <= 16'(sel_color[7:0]) * 16'(sel_color[31:24]);
         on_ff     <= sel_on;
         off_ff    <= sel_off;
         blink_ff  <= blink_in;
      end
   end

   // alpha scaling and blink timing
   assign scale_en = (alpha_ff != 8'd0) && (alpha_ff != 8'hff);
   assign span_ms  = 16'(step_cfg_ff) * 16'(RAMP_SPAN);

   always_comb begin
      step_in = '0;
      phi_in  = '0;
      if (blink_ff) begin
         if (span_ms > on_ff) begin
            step_in = 8'(on_ff / RAMP_SPAN);
            phi_in  = '0;
         end else begin
            step_in = step_cfg_ff;
            phi_in  = on_ff - span_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         lvl_r_ff <= scale_en ? 8'(div255(prod_r_ff)) : raw_r_ff;
         lvl_g_ff <= scale_en ? 8'(div255(prod_g_ff)) : raw_g_ff;
         lvl_b_ff <= scale_en ? 8'(div255(prod_b_ff)) : raw_b_ff;
         step_ff  <= step_in;
         phi_ff   <= phi_in;
         plo_ff   <= blink_ff ? off_ff : 16'd0;
      end
   end

   assign status.blink = blink_ff;

   // per ramp point duty
   assign pct    = ramp_pct(cmd.idx);
   assign duty_r = div255(16'(pct) * 16'(lvl_r_ff));
   assign duty_g = div255(16'(pct) * 16'(lvl_g_ff));
   assign duty_b = div255(16'(pct) * 16'(lvl_b_ff));

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         o_blink_ff <= blink_ff;
         o_r_ff     <= lvl_r_ff;
         o_g_ff     <= lvl_g_ff;
         o_b_ff     <= lvl_b_ff;
         o_idx_ff   <= blink_ff ? 3'(cmd.idx) : 3'd0;
         o_rd_ff    <= blink_ff ? duty_r[6:0] : 7'd0;
         o_gd_ff    <= blink_ff ? duty_g[6:0] : 7'd0;
         o_bd_ff    <= blink_ff ? duty_b[6:0] : 7'd0;
         o_step_ff  <= step_ff;
         o_phi_ff   <= phi_ff;
         o_plo_ff   <= plo_ff;
         o_last_ff  <= cmd.last;
      end
   end

   assign rsp_blink       = o_blink_ff;
   assign rsp_red_level   = o_r_ff;
   assign rsp_green_level = o_g_ff;
   assign rsp_blue_level  = o_b_ff;
   assign rsp_ramp_index  = o_idx_ff;
   assign rsp_red_duty    = o_rd_ff;
   assign rsp_green_duty  = o_gd_ff;
   assign rsp_blue_duty   = o_bd_ff;
   assign rsp_step_ms     = o_step_ff;
   assign rsp_pause_hi_ms = o_phi_ff;
   assign rsp_pause_lo_ms = o_plo_ff;
   assign rsp_last        = o_last_ff;

`ifndef SYNTHESIS
   a_steady_no_duty: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out && !blink_ff |=> rsp_red_duty == 7'd0 && rsp_step_ms == 8'd0 && rsp_last)
      else $error("steady result carries ramp data");

   a_blink_lit: assert property (@(posedge clock) disable iff (reset)
      cmd.select && blink_in |-> sel_color[23:0] != 24'd0)
      else $error("blink chosen for unlit source");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scale && blink_ff |=> 16'(step_ff) * 16'(RAMP_SPAN) + phi_ff <= on_ff)
      else $error("ramp timing exceeds on time");
`endif

endmodule

// File: hdl/rgb_indicator_led_pattern_setup_core.sv
// RGB indicator pattern setup. Each request transaction overwrites one of three
// light sources (notification, attention, battery; command 3 writes nothing) and
// then reports the first lit source in that order, with RGB scaled by alpha for
// alpha 1 to 254. A timed source with nonzero on and off times gives eight ramp
// results (blink set, last on the eighth); anything else gives one result, all
// zero but for rsp_last when nothing is lit. A request is taken only while the
// block is idle and occupies it through these steps: write the source store,
// pick the source and form the alpha products, scale and work out step and pause
// times, then pass each result through the output register, waiting while a
// result already there is not yet taken. ramp_step_ms sits at byte addresses 0
// to 3 of the register port and resets to 50.
module rgb_indicator_led_pattern_setup_core
   import rgbled_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic [31:0]           req_color,
   input  logic                  req_timed,
   input  logic [15:0]           req_on_ms,
   input  logic [15:0]           req_off_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_blink,
   output logic [7:0]            rsp_red_level,
   output logic [7:0]            rsp_green_level,
   output logic [7:0]            rsp_blue_level,
   output logic [2:0]            rsp_ramp_index,
   output logic [6:0]            rsp_red_duty,
   output logic [6:0]            rsp_green_duty,
   output logic [6:0]            rsp_blue_duty,
   output logic [7:0]            rsp_step_ms,
   output logic [15:0]           rsp_pause_hi_ms,
   output logic [15:0]           rsp_pause_lo_ms,
   output logic                  rsp_last
);

   cmd_type    cmd;
   status_type status;

   assign csr_pready = 1'b1;

   rgbled_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rgbled_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .req_cmd         (req_cmd),
      .req_color       (req_color),
      .req_timed       (req_timed),
      .req_on_ms       (req_on_ms),
      .req_off_ms      (req_off_ms),
      .cmd             (cmd),
      .status          (status),
      .rsp_blink       (rsp_blink),
      .rsp_red_level   (rsp_red_level),
      .rsp_green_level (rsp_green_level),
      .rsp_blue_level  (rsp_blue_level),
      .rsp_ramp_index  (rsp_ramp_index),
      .rsp_red_duty    (rsp_red_duty),
      .rsp_green_duty  (rsp_green_duty),
      .rsp_blue_duty   (rsp_blue_duty),
      .rsp_step_ms     (rsp_step_ms),
      .rsp_pause_hi_ms (rsp_pause_hi_ms),
      .rsp_pause_lo_ms (rsp_pause_lo_ms),
      .rsp_last        (rsp_last)
   );

endmodule
